[hw/rtl/rbst_pkg.sv]
// Package for the ray/box slab test core: shared constants and types.
// No dependencies.
package rbst_pkg;
  localparam logic OP_EXTEND = 1'b0;
  localparam logic OP_HIT    = 1'b1;
  localparam int   NUM_AXES  = 3;
  localparam int   BOX_RESET_INT = 999;

  // per-lane divider status toward the merge stage
  typedef struct packed {
    logic busy;
  } lane_stat_t;
endpackage

[hw/rtl/rbst_if.sv]
// Valid/ready channel interface carrying one item of payload.
// No dependencies.
interface rbst_if #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input logic clk
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/ray_box_slab_test_core.sv]
// Ray versus axis-aligned box slab test core, signed fixed point.
// Extend items update the box at acceptance, no result; a hit item passes through
// S_RUN while the slab dividers work and then S_MERGE, which loads the result register.
// A new item is taken only in S_IDLE, so the bit-serial slab dividers bound the
// rate of hit items; the result register lets the next item enter while a result waits.
// Reset (synchronous, rst high): box low 999.0, high -999.0. Depends on rbst_pkg, rbst_if.
module ray_box_slab_test_core #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input logic clk,
  input logic rst,
  rbst_if.sink   in_ch,
  rbst_if.source out_ch
);
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned NA = rbst_pkg::NUM_AXES;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_MERGE} state_t;
  state_t state;

  logic                 op;
  logic signed [CW-1:0] pos [NA];
  logic signed [CW-1:0] dir [NA];
  logic signed [CW-1:0] lo  [NA];
  logic signed [CW-1:0] hi  [NA];
  rbst_pkg::lane_stat_t stat [NA];

  assign op = in_ch.data[0];
  for (genvar k = 0; k < NA; k++) begin : g_unpack
    assign pos[k] = in_ch.data[1 + k*CW +: CW];
    assign dir[k] = in_ch.data[1 + (NA+k)*CW +: CW];
  end

  logic accept, out_free, lanes_busy;
  assign out_free = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign accept = in_ch.valid && in_ch.ready;

  for (genvar k = 0; k < NA; k++) begin : g_lane
    rbst_lane #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk(clk), .rst(rst),
      .extend(accept && op == rbst_pkg::OP_EXTEND),
      .start(accept && op == rbst_pkg::OP_HIT),
      .pos(pos[k]), .dir(dir[k]),
      .stat(stat[k]), .t_lo(lo[k]), .t_hi(hi[k]));
  end

  // any lane still dividing
  always_comb begin
    lanes_busy = 1'b0;
    for (int k = 0; k < NA; k++) lanes_busy = lanes_busy | stat[k].busy;
  end

  // merge stage: intersect the three intervals, then replace a negative bound by the other (miss if both are negative)
  logic signed [CW-1:0] tmin, tmax, tmin1, tmax1, tsw;
  logic hit;
  always_comb begin
    hit  = 1'b1;
    tmin = lo[0];
    tmax = hi[0];
    for (int k = 1; k < NA; k++) begin
      if (hit) begin
        if (tmin > hi[k] || lo[k] > tmax) hit = 1'b0;
        else begin
          if (lo[k] > tmin) tmin = lo[k];
          if (hi[k] < tmax) tmax = hi[k];
        end
      end
    end
    tmin1 = tmin;
    tmax1 = tmax;
    if (hit && tmin1 < 0) begin
      tmin1 = tmax1;
      if (tmin1 < 0) hit = 1'b0;
    end
    if (hit && tmax1 < 0) begin
      tmax1 = tmin1;
      if (tmax1 < 0) hit = 1'b0;
    end
    if (hit && tmin1 > tmax1) begin
      tsw = tmin1; tmin1 = tmax1; tmax1 = tsw;
    end else begin
      tsw = tmin1;
    end
  end

  // control and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      priority if (state == S_MERGE && out_free) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE:  if (accept && op == rbst_pkg::OP_HIT) state <= S_RUN;
        S_RUN:   if (!lanes_busy) state <= S_MERGE;
        S_MERGE: if (out_free) begin
          out_ch.data  <= hit ? {tmax1, tmin1, 1'b1} : '0;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[hw/rtl/rbst_div.sv]
// Iterative restoring divider for one slab plane: (a - b) * 2^FRAC / den,
// truncated toward zero and saturated. Depends on rbst_pkg.
module rbst_div #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [COORD_WIDTH-1:0] a,
  input  logic signed [COORD_WIDTH-1:0] b,
  input  logic signed [COORD_WIDTH-1:0] den,
  output rbst_pkg::lane_stat_t          stat,
  output logic signed [COORD_WIDTH-1:0] quo
);
  localparam int unsigned NW = COORD_WIDTH + 1;          // magnitude of a-b
  localparam int unsigned DW = NW + FRAC_BITS;           // dividend bits
  localparam int unsigned CW = $clog2(DW + 1);
  localparam logic [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};

  logic [DW-1:0]          dvd;
  logic [COORD_WIDTH:0]   rem;
  logic [DW-1:0]          q;
  logic [COORD_WIDTH-1:0] d;
  logic [CW-1:0]          cnt;
  logic                   busy, neg, nneg, dz;

  logic signed [NW-1:0]   diff;
  logic [NW-1:0]          mag;
  logic [COORD_WIDTH-1:0] dmag;
  logic [COORD_WIDTH+1:0] rsh;
  logic [COORD_WIDTH+1:0] rsub;

  assign diff = NW'(a) - NW'(b);
  assign mag  = diff[NW-1] ? NW'(-diff) : NW'(diff);
  assign dmag = den[COORD_WIDTH-1] ? COORD_WIDTH'(-den) : den;
  assign rsh  = {rem, dvd[DW-1]};
  assign rsub = rsh - {2'b00, d};

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      if (start) begin
        busy <= (den != '0);
        dz   <= (den == '0);
        nneg <= diff[NW-1];
        neg  <= diff[NW-1] ^ den[COORD_WIDTH-1];
        dvd  <= {mag, {FRAC_BITS{1'b0}}};
        d    <= dmag;
        rem  <= '0;
        q    <= '0;
        cnt  <= CW'(DW);
      end else if (busy) begin
        dvd <= dvd << 1;
        if (!rsub[COORD_WIDTH+1]) begin
          rem <= rsub[COORD_WIDTH:0];
          q   <= {q[DW-2:0], 1'b1};
        end else begin
          rem <= rsh[COORD_WIDTH:0];
          q   <= {q[DW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // saturate and apply sign
  logic [DW-1:0] lim;
  logic [DW-1:0] qs;
  always_comb begin
    lim = neg ? DW'(MAXV) + DW'(1) : DW'(MAXV);
    qs  = (q > lim) ? lim : q;
    if (dz)
      quo = nneg ? -$signed(MAXV) : $signed(MAXV);
    else if (neg)
      quo = COORD_WIDTH'(-qs);
    else
      quo = COORD_WIDTH'(qs);
  end

  assign stat.busy = busy;
endmodule

[hw/rtl/rbst_lane.sv]
// One axis lane: box corners for the axis and the two slab dividers,
// returns the ordered entry/exit pair. Depends on rbst_pkg, rbst_div.
module rbst_lane #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          extend,
  input  logic                          start,
  input  logic signed [COORD_WIDTH-1:0] pos,
  input  logic signed [COORD_WIDTH-1:0] dir,
  output rbst_pkg::lane_stat_t          stat,
  output logic signed [COORD_WIDTH-1:0] t_lo,
  output logic signed [COORD_WIDTH-1:0] t_hi
);
  localparam int unsigned RW = COORD_WIDTH + FRAC_BITS + 12;
  localparam logic signed [RW-1:0] CR   = RW'(rbst_pkg::BOX_RESET_INT) <<< FRAC_BITS;
  localparam logic signed [RW-1:0] MAXW = RW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [RW-1:0] MINW = -MAXW - RW'(1);
  localparam logic signed [COORD_WIDTH-1:0] LOW_RST =
    COORD_WIDTH'((CR > MAXW) ? MAXW : CR);
  localparam logic signed [COORD_WIDTH-1:0] HIGH_RST =
    COORD_WIDTH'((-CR < MINW) ? MINW : -CR);

  logic signed [COORD_WIDTH-1:0] low_c, high_c, q0, q1;
  rbst_pkg::lane_stat_t s0, s1;

  // box corners for this axis
  always_ff @(posedge clk) begin
    if (rst) begin
      low_c  <= LOW_RST;
      high_c <= HIGH_RST;
    end else if (extend) begin
      if (pos < low_c)  low_c  <= pos;
      if (pos > high_c) high_c <= pos;
    end
  end

  rbst_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_lo (
    .clk(clk), .rst(rst), .start(start), .a(low_c), .b(pos), .den(dir),
    .stat(s0), .quo(q0));
  rbst_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_hi (
    .clk(clk), .rst(rst), .start(start), .a(high_c), .b(pos), .den(dir),
    .stat(s1), .quo(q1));

  // both dividers run in lockstep
  assign stat.busy = s0.busy | s1.busy;
  assign t_lo = (q0 > q1) ? q1 : q0;
  assign t_hi = (q0 > q1) ? q0 : q1;
endmodule
